// ===== sv/mwpo_pkg.sv =====
package mwpo_pkg;

    localparam int WAVE_SEL_W = 2;
    localparam int STEP_W     = 20;
    localparam int CFG_IDX_W  = 1;

    // wave select codes
    localparam logic [WAVE_SEL_W-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WAVE_SEL_W-1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [WAVE_SEL_W-1:0] WAVE_SAW      = 2'd2;
    localparam logic [WAVE_SEL_W-1:0] WAVE_PULSE    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SCALE  = 1'd1;

    localparam logic [STEP_W-1:0] STEP_SCALE_RST = 20'd97392;

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_RESET  = 1'b1;

    localparam int SINE_W = 31;  // 0 .. 2^30

    // One quarter-wave table entry: sin(pi/2*k/2^bits) in Q30, truncating
    // Horner series through x^15. Evaluated at elaboration only.
    function automatic logic [SINE_W-1:0] sine_entry(input int k, input int bits);
        longint unsigned one;
        longint unsigned half_pi;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        one     = 64'd1 << 30;
        half_pi = 64'd1686629713;
        x  = (half_pi * longint'(k) + ((64'd1 << bits) >> 1)) >> bits;
        x2 = (x * x) >> 30;
        t  = one;
        t  = one - (((x2 * t) >> 30) / 210);
        t  = one - (((x2 * t) >> 30) / 156);
        t  = one - (((x2 * t) >> 30) / 110);
        t  = one - (((x2 * t) >> 30) / 72);
        t  = one - (((x2 * t) >> 30) / 42);
        t  = one - (((x2 * t) >> 30) / 20);
        t  = one - (((x2 * t) >> 30) / 6);
        s  = (x * t) >> 30;
        if (s > one) begin
            s = one;
        end
        return s[SINE_W-1:0];
    endfunction

endpackage

// ===== sv/mwpo_sine_rom.sv =====
module mwpo_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [TABLE_BITS:0]   i_addr,
    output logic [30:0]           o_data
);
    import mwpo_pkg::*;

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    logic [SINE_W-1:0] rom_table [DEPTH];
    logic [SINE_W-1:0] r_data;

    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        assign rom_table[k] = sine_entry(k, TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_table[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== sv/multi_waveform_phase_oscillator.sv =====
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_action, i_frequency, i_phase_offset,
//                                       i_pulse_width, i_range_low, i_range_high
// output    o_out_valid   i_out_stall   o_sample
// config    i_cfg_we      (none)        i_cfg_index, i_cfg_data
//
// One transaction per cycle while o_in_stall is low. A sample passes these registered steps:
// sine ROM read, wave/range prep, 32x33 multiply, round/offset into the output reg.
// The phase step is held as base + increment + offset delta, summed at the next
// transaction, so the only loop is that 32-bit add. Reset (sync, active low)
// clears phase, last offset, config and all valid bits. A stalled output
// stalls each stage only once the stages behind it are full.
module multi_waveform_phase_oscillator #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic signed [23:0]         i_frequency,
    input  logic [31:0]                i_phase_offset,
    input  logic [15:0]                i_pulse_width,
    input  logic signed [31:0]         i_range_low,
    input  logic signed [31:0]         i_range_high,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [31:0]         o_sample,
    input  logic                       i_cfg_we,
    input  logic [mwpo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mwpo_pkg::STEP_W-1:0]    i_cfg_data
);
    import mwpo_pkg::*;

    localparam int B = SINE_TABLE_BITS;
    localparam logic [B:0] SINE_N = (B+1)'(1) << B;
    localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;
    localparam logic signed [33:0] TWO_P31 = 34'sh0_8000_0000;
    localparam logic signed [33:0] TWO_P32 = 34'sh1_0000_0000;

    // configuration
    logic [WAVE_SEL_W-1:0] r_wave_sel;
    logic [STEP_W-1:0]     r_step_scale;

    // phase state
    logic [31:0] r_base, r_mul, r_delta, r_last_offset;

    // pipeline
    logic               r1_v, r2_v, r3_v, r_out_v;
    logic [31:0]        r1_phase;
    logic [15:0]        r1_pw;
    logic signed [31:0] r1_lo, r1_hi, r2_lo, r3_lo;
    logic [31:0]        r2_a;
    logic signed [32:0] r2_d;
    logic signed [65:0] r3_prod;
    logic signed [31:0] r_sample;

    logic adv_o, adv3, adv2, adv1, in_acc;
    logic [31:0] phase;
    logic [B-1:0] sine_idx;
    logic [B:0] rom_addr;
    logic [30:0] rom_data;
    logic signed [44:0] n_mul_full;
    logic signed [33:0] w, p_ext;
    logic signed [33:0] n_a_full;
    logic signed [65:0] n_prod;
    logic signed [65:0] rnd;
    logic signed [34:0] q;
    logic signed [35:0] res;
    logic signed [31:0] n_sample;

    assign adv_o  = !r_out_v || !i_out_stall;
    assign adv3   = !r3_v || adv_o;
    assign adv2   = !r2_v || adv3;
    assign adv1   = !r1_v || adv2;
    assign o_in_stall = !adv1;
    assign in_acc = i_in_valid && adv1;

    // phase of this transaction: last base plus pending increments
    assign phase = r_base + r_mul + r_delta;

    assign sine_idx = phase[29 -: B];
    assign rom_addr = phase[30] ? (SINE_N - {1'b0, sine_idx}) : {1'b0, sine_idx};

    mwpo_sine_rom #(
        .TABLE_BITS (B)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (adv1),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    assign n_mul_full = i_frequency * $signed({1'b0, r_step_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel   <= WAVE_SINE;
            r_step_scale <= STEP_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVE_SELECT: r_wave_sel   <= i_cfg_data[WAVE_SEL_W-1:0];
                CFG_STEP_SCALE:  r_step_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= '0;
            r_mul         <= '0;
            r_delta       <= '0;
            r_last_offset <= '0;
        end else if (in_acc) begin
            if (i_action == ACT_RESET) begin
                r_base  <= '0;
                r_mul   <= '0;
                r_delta <= '0;
            end else begin
                r_base        <= phase;
                r_mul         <= n_mul_full[39:8];
                r_delta       <= i_phase_offset - r_last_offset;
                r_last_offset <= i_phase_offset;
            end
        end
    end

    // stage 1: phase and fields beside the ROM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv1) begin
            r1_v <= in_acc && (i_action == ACT_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_phase <= phase;
            r1_pw    <= i_pulse_width;
            r1_lo    <= i_range_low;
            r1_hi    <= i_range_high;
        end
    end

    // wave value in Q2.30
    assign p_ext = $signed({2'b00, r1_phase});

    always_comb begin
        case (r_wave_sel)
            WAVE_SINE: begin
                w = $signed({3'b000, rom_data});
                if (r1_phase[31]) begin
                    w = -w;
                end
            end
            WAVE_TRIANGLE: begin
                case (r1_phase[31:30])
                    2'd0:    w = p_ext;
                    2'd3:    w = p_ext - TWO_P32;
                    default: w = TWO_P31 - p_ext;
                endcase
            end
            WAVE_SAW: w = $signed({3'b000, r1_phase[31:1]}) - ONE_Q30;
            default:  w = (r1_phase < {r1_pw, 16'h0000}) ? ONE_Q30 : -ONE_Q30;
        endcase
    end

    assign n_a_full = w + ONE_Q30;

    // stage 2: multiplier operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_a  <= n_a_full[31:0];
            r2_d  <= 33'(r1_hi) - 33'(r1_lo);
            r2_lo <= r1_lo;
        end
    end

    assign n_prod = $signed({1'b0, r2_a}) * r2_d;

    // stage 3: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_prod <= n_prod;
            r3_lo   <= r2_lo;
        end
    end

    // round half away from zero: negative products take one less bias
    assign rnd = r3_prod + 66'sh4000_0000 - 66'(r3_prod[65]);
    assign q   = rnd[65:31];
    assign res = 36'(r3_lo) + 36'(q);

    always_comb begin
        if (res > 36'sh0_7FFF_FFFF) begin
            n_sample = 32'sh7FFF_FFFF;
        end else if (res < -36'sh0_8000_0000) begin
            n_sample = 32'sh8000_0000;
        end else begin
            n_sample = res[31:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv_o) begin
            r_out_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o) begin
            r_sample <= n_sample;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_sample    = r_sample;

endmodule

// ===== sim/osc_sample_checker.sv =====
`timescale 1ns / 100ps
module osc_sample_checker #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_action,
    input  logic signed [23:0]              i_frequency,
    input  logic [31:0]                     i_phase_offset,
    input  logic [15:0]                     i_pulse_width,
    input  logic signed [31:0]              i_range_low,
    input  logic signed [31:0]              i_range_high,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic signed [31:0]              i_sample,
    input  logic                            i_cfg_we,
    input  logic [mwpo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mwpo_pkg::STEP_W-1:0]     i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import mwpo_pkg::*;

    localparam int              SINE_N      = 1 << SINE_TABLE_BITS;
    localparam longint          UNITY       = 64'sd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          SAMPLE_MAX  = 64'sd2147483647;
    localparam longint          SAMPLE_MIN  = -64'sd2147483648;

    longint quarter_sine [0:SINE_N];

    logic [WAVE_SEL_W-1:0] wave_sel;
    logic [STEP_W-1:0]     step_scale;
    logic [31:0]           phase_acc;
    logic [31:0]           last_offset;
    logic signed [31:0]    expected_samples [$];
    int                    fails = 0;

    // truncating Q30 Horner series for sin(pi/2 * k / N)
    function automatic longint sine_q30(input int k);
        longint unsigned divisors [7] = '{210, 156, 110, 72, 42, 20, 6};
        longint unsigned unity_u;
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        unity_u = 64'd1 << 30;
        kk = k;
        x  = (HALF_PI_Q30 * kk + (64'(SINE_N) >> 1)) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = unity_u;
        foreach (divisors[j]) begin
            t = unity_u - (((x2 * t) >> 30) / divisors[j]);
        end
        s = (x * t) >> 30;
        if (s > unity_u) begin
            s = unity_u;
        end
        return longint'(s);
    endfunction

    initial begin
        for (int k = 0; k <= SINE_N; k++) begin
            quarter_sine[k] = sine_q30(k);
        end
    end

    // wave level in Q2.30 at the given phase
    function automatic longint wave_level(input logic [31:0] ph, input logic [15:0] pw);
        logic [1:0]  quad;
        int unsigned idx;
        longint      mag;
        longint      pp;
        quad = ph[31:30];
        pp   = longint'(ph);
        case (wave_sel)
            WAVE_SINE: begin
                idx = ph[29:0] >> (30 - SINE_TABLE_BITS);
                mag = quad[0] ? quarter_sine[SINE_N - idx] : quarter_sine[idx];
                return quad[1] ? -mag : mag;
            end
            WAVE_TRIANGLE: begin
                if (quad == 2'd0) begin
                    return pp;
                end else if (quad == 2'd3) begin
                    return pp - (64'sd1 << 32);
                end
                return (64'sd1 << 31) - pp;
            end
            WAVE_SAW: return longint'(ph >> 1) - UNITY;
            default:  return (ph < {pw, 16'h0000}) ? UNITY : -UNITY;
        endcase
    endfunction

    function automatic logic signed [31:0] scaled_sample(input longint w,
                                                         input logic signed [31:0] lo,
                                                         input logic signed [31:0] hi);
        longint prod;
        longint q;
        longint r;
        prod = (w + UNITY) * (longint'(hi) - longint'(lo));
        // round half away from zero
        if (prod >= 0) begin
            q = (prod + UNITY) >> 31;
        end else begin
            q = -((-prod + UNITY) >> 31);
        end
        r = longint'(lo) + q;
        if (r > SAMPLE_MAX) begin
            r = SAMPLE_MAX;
        end
        if (r < SAMPLE_MIN) begin
            r = SAMPLE_MIN;
        end
        return r[31:0];
    endfunction

    always @(posedge i_clk) begin
        longint             step_prod;
        logic signed [31:0] want;
        if (!i_rst_n) begin
            wave_sel    = WAVE_SINE;
            step_scale  = STEP_SCALE_RST;
            phase_acc   = '0;
            last_offset = '0;
            expected_samples.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WAVE_SELECT: wave_sel   = i_cfg_data[WAVE_SEL_W-1:0];
                    CFG_STEP_SCALE:  step_scale = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_RESET) begin
                    phase_acc = '0;
                end else begin
                    want = scaled_sample(wave_level(phase_acc, i_pulse_width),
                                         i_range_low, i_range_high);
                    expected_samples.insert(expected_samples.size(), want);
                    step_prod   = longint'(i_frequency) * longint'(step_scale);
                    phase_acc   = phase_acc + step_prod[39:8] + (i_phase_offset - last_offset);
                    last_offset = i_phase_offset;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample transaction, expected none, got %0d",
                             $time, i_sample);
                    fails++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_sample !== want) begin
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $time, want, i_sample);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_samples.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import mwpo_pkg::*;

    localparam int TABLE_BITS       = 10;
    localparam int DRAIN_CYCLES     = 8;
    localparam int NUM_PHASES       = 8;
    localparam int FIXED_PHASES     = 4;
    localparam int DIRECTED_ITEMS   = 6;
    localparam int RANDOM_PER_PHASE = 110;

    localparam logic [WAVE_SEL_W-1:0] FIXED_WAVES [FIXED_PHASES] =
        '{WAVE_SINE, WAVE_TRIANGLE, WAVE_SAW, WAVE_PULSE};
    localparam logic [STEP_W-1:0] FIXED_STEPS [FIXED_PHASES] =
        '{STEP_SCALE_RST, 20'd1, 20'hFFFFF, 20'd0};

    typedef struct packed {
        logic               act;
        logic signed [23:0] freq;
        logic [31:0]        offset;
        logic [15:0]        pw;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_osc_item;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_action;
    logic signed [23:0]    i_frequency;
    logic [31:0]           i_phase_offset;
    logic [15:0]           i_pulse_width;
    logic signed [31:0]    i_range_low;
    logic signed [31:0]    i_range_high;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [31:0]    o_sample;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [STEP_W-1:0]     i_cfg_data;

    int fail_count;
    int samples_pending;
    int burst_left = 0;
    logic [31:0] cur_offset = '0;

    always #5 i_clk = ~i_clk;

    multi_waveform_phase_oscillator #(.SINE_TABLE_BITS(TABLE_BITS)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_frequency    (i_frequency),
        .i_phase_offset (i_phase_offset),
        .i_pulse_width  (i_pulse_width),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample       (o_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    osc_sample_checker #(.SINE_TABLE_BITS(TABLE_BITS)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_frequency    (i_frequency),
        .i_phase_offset (i_phase_offset),
        .i_pulse_width  (i_pulse_width),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_sample       (o_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (samples_pending)
    );

    // output stall pattern: random modes of no, light, heavy or run-length stalls
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;
    logic        run_level  = 1'b0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (run_left == 0) begin
                    run_level = ~run_level;
                    run_left  = $urandom_range(1, 12);
                end
                run_left--;
                i_out_stall <= run_level;
            end
        endcase
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender bursts: after a burst, often drop valid for a random gap
    task automatic send_item(input t_osc_item it);
        int gap;
        i_in_valid     <= 1'b1;
        i_action       <= it.act;
        i_frequency    <= it.freq;
        i_phase_offset <= it.offset;
        i_pulse_width  <= it.pw;
        i_range_low    <= it.lo;
        i_range_high   <= it.hi;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // reset actions emit nothing, so let the pipe drain past the last sample
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (samples_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_osc_item directed_item(input int d);
        t_osc_item it;
        it     = '0;
        it.act = ACT_SAMPLE;
        case (d)
            0: begin
                it.act  = ACT_RESET;
                it.freq = 24'sh123456;
                it.lo   = 32'sh7FFFFFFF;
            end
            1: begin
                it.freq = 24'sh7FFFFF;
                it.lo   = 32'sh80000000;
                it.hi   = 32'sh7FFFFFFF;
            end
            2: begin
                // inverted full range, offset and width at their tops
                it.freq   = 24'sh800000;
                it.offset = 32'hFFFFFFFF;
                it.pw     = 16'hFFFF;
                it.lo     = 32'sh7FFFFFFF;
                it.hi     = 32'sh80000000;
            end
            3: begin
                it.offset = 32'h40000000;
                it.pw     = 16'h8000;
            end
            4: begin
                it.freq   = 24'sd256;
                it.offset = 32'h80000000;
                it.lo     = -32'sd1000;
                it.hi     = 32'sd1000;
            end
            default: begin
                it.freq = -24'sd256;
                it.pw   = 16'h0001;
                it.lo   = 32'sh7FFFFFFF;
                it.hi   = 32'sh7FFFFFFF;
            end
        endcase
        return it;
    endfunction

    function automatic logic signed [31:0] random_level();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            8:             return 32'sh7FFFFFFF;
            default:       return 32'sh80000000;
        endcase
    endfunction

    function automatic t_osc_item random_item();
        t_osc_item it;
        it.act = ($urandom_range(0, 19) == 0) ? ACT_RESET : ACT_SAMPLE;
        case ($urandom_range(0, 3))
            0:       it.freq = 24'($urandom);
            1:       it.freq = 24'($urandom_range(0, 4000));
            2:       it.freq = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
            default: it.freq = 24'($urandom_range(0, 2000)) << 8;
        endcase
        if ($urandom_range(0, 1) != 0) begin
            it.freq = -it.freq;
        end
        // offset mostly held, sometimes jumps or drifts
        if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 1) != 0) begin
                cur_offset = $urandom;
            end else begin
                cur_offset = cur_offset + $urandom_range(0, 1 << 20);
            end
        end
        it.offset = cur_offset;
        case ($urandom_range(0, 7))
            0:       it.pw = 16'h0000;
            1:       it.pw = 16'hFFFF;
            default: it.pw = 16'($urandom);
        endcase
        it.lo = random_level();
        it.hi = ($urandom_range(0, 9) == 0) ? it.lo : random_level();
        return it;
    endfunction

    initial begin
        logic [WAVE_SEL_W-1:0] wave;
        logic [STEP_W-1:0]     step;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_action       <= ACT_SAMPLE;
        i_frequency    <= '0;
        i_phase_offset <= '0;
        i_pulse_width  <= '0;
        i_range_low    <= '0;
        i_range_high   <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_WAVE_SELECT;
        i_cfg_data     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_idle();
            end
            if (ph < FIXED_PHASES) begin
                wave = FIXED_WAVES[ph];
                step = FIXED_STEPS[ph];
            end else begin
                wave = WAVE_SEL_W'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:       step = STEP_W'($urandom);
                    1:       step = STEP_W'($urandom_range(1, 64));
                    default: step = STEP_W'($urandom_range(1, 200000));
                endcase
            end
            write_reg(CFG_WAVE_SELECT, STEP_W'(wave));
            write_reg(CFG_STEP_SCALE, step);
            if (ph < FIXED_PHASES) begin
                for (int d = 0; d < DIRECTED_ITEMS; d++) begin
                    send_item(directed_item(d));
                end
            end
            repeat (RANDOM_PER_PHASE) send_item(random_item());
            i_in_valid <= 1'b0;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
